/* rtl/ham_palette_pixel_decoder_core_macros.svh */
// Assertion helpers shared by the decoder RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef HAM_PALETTE_PIXEL_DECODER_CORE_MACROS_SVH
`define HAM_PALETTE_PIXEL_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define HPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hpd_pkg.sv */
package hpd_pkg;

  // Palette geometry
  localparam int PalDepth = 256;
  localparam int PalAw    = $clog2(PalDepth);

  // APB register map
  localparam int PaddrW = 3;
  localparam logic RegColorMode  = 1'b0;
  localparam logic RegMaskEnable = 1'b1;

  // Color modes (code 3 decodes as indexed)
  localparam logic [1:0] ModeIndexed = 2'd0;
  localparam logic [1:0] ModeHam6    = 2'd1;
  localparam logic [1:0] ModeHam8    = 2'd2;

  // Input opcodes
  localparam logic OpPixel    = 1'b0;
  localparam logic OpPalWrite = 1'b1;

  // HAM control field
  localparam logic [1:0] SelLoad  = 2'd0;
  localparam logic [1:0] SelBlue  = 2'd1;
  localparam logic [1:0] SelRed   = 2'd2;
  localparam logic [1:0] SelGreen = 2'd3;

  // Per-pixel control carried from issue to the color stage
  typedef struct packed {
    logic [1:0] mode;
    logic       mask_en;
    logic       row_start;
    logic [7:0] pixel_value;
    logic       mask_bit;
  } pix_ctl_t;

  // Entry outside the palette reads as zero
  function automatic logic in_range(input logic [7:0] idx);
    return {1'b0, idx} < 9'(PalDepth);
  endfunction

  // Palette entry a pixel needs: indexed code, HAM load base, or entry 0
  // for a row-start reload.
  function automatic logic [7:0] pal_addr(input logic [1:0] mode,
                                          input logic [7:0] pv);
    logic [7:0] addr;
    addr = pv;
    if (mode == ModeHam6) begin
      addr = (pv[5:4] == SelLoad) ? {4'd0, pv[3:0]} : 8'd0;
    end else if (mode == ModeHam8) begin
      addr = (pv[7:6] == SelLoad) ? {2'd0, pv[5:0]} : 8'd0;
    end
    return addr;
  endfunction

endpackage

/* rtl/hpd_if.sv */
// Input word channel
interface hpd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        row_start;
  logic [7:0]  pixel_value;
  logic        mask_bit;
  logic [7:0]  entry_index;
  logic [31:0] entry_word;

  modport source (output valid, opcode, row_start, pixel_value, mask_bit,
                  entry_index, entry_word, input ready);
  modport sink   (input valid, opcode, row_start, pixel_value, mask_bit,
                  entry_index, entry_word, output ready);
endinterface

// Output pixel channel
interface hpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

/* rtl/hpd_ram.sv */
// Single write port, single read port RAM with registered read data.
module hpd_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/hpd_palette.sv */
// Palette store: RAM plus per-entry written flags so that entries read
// zero after reset without a clearing pass.
module hpd_palette (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [7:0]  widx_i,
  input  logic [31:0] wword_i,
  input  logic        re_i,
  input  logic [7:0]  ridx_i,
  output logic [31:0] rword_o
);

  logic [hpd_pkg::PalDepth-1:0] vld_q;
  logic                         hit_q;
  logic                         wr_ok;
  logic                         rd_ok;
  logic [31:0]                  ram_rdata;

  assign wr_ok = we_i && hpd_pkg::in_range(widx_i);
  assign rd_ok = hpd_pkg::in_range(ridx_i);

  hpd_ram #(
    .Width(32),
    .Depth(hpd_pkg::PalDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(widx_i[hpd_pkg::PalAw-1:0]),
    .wdata_i(wword_i),
    .re_i   (re_i),
    .raddr_i(ridx_i[hpd_pkg::PalAw-1:0]),
    .rdata_o(ram_rdata)
  );

  // Written flags; hit sampled alongside the RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_q[widx_i[hpd_pkg::PalAw-1:0]] <= 1'b1;
      end
      if (re_i) begin
        hit_q <= rd_ok && vld_q[ridx_i[hpd_pkg::PalAw-1:0]];
      end
    end
  end

  assign rword_o = hit_q ? ram_rdata : 32'd0;

endmodule

/* rtl/hpd_pixel.sv */
`include "ham_palette_pixel_decoder_core_macros.svh"

// Color stage: takes the palette word read for a pixel, applies the
// indexed/HAM rules against the held color, and registers the result.
module hpd_pixel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              issue_i,
  input  hpd_pkg::pix_ctl_t ctl_i,
  output logic              ready_o,
  input  logic [31:0]       word_i,
  hpd_out_if.source         out_if
);

  hpd_pkg::pix_ctl_t s1_q;
  logic              s1_valid_q;
  logic              out_valid_q;
  logic              adv;
  logic [7:0]        red_hold_q, green_hold_q, blue_hold_q;
  logic [7:0]        red_d, green_d, blue_d, alpha_d;
  logic [7:0]        red_q, green_q, blue_q, alpha_q;
  logic [7:0]        base_r, base_g, base_b;
  logic [7:0]        comp;
  logic [1:0]        sel;
  logic              ham6, ham8;

  assign adv     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign ready_o = !s1_valid_q || !out_valid_q || out_if.ready;

  // Color rules
  always_comb begin
    ham6   = s1_q.mode == hpd_pkg::ModeHam6;
    ham8   = s1_q.mode == hpd_pkg::ModeHam8;
    sel    = ham6 ? s1_q.pixel_value[5:4] : s1_q.pixel_value[7:6];
    comp   = ham6 ? {s1_q.pixel_value[3:0], s1_q.pixel_value[3:0]}
                  : {s1_q.pixel_value[5:0], s1_q.pixel_value[5:4]};
    base_r = s1_q.row_start ? word_i[23:16] : red_hold_q;
    base_g = s1_q.row_start ? word_i[15:8]  : green_hold_q;
    base_b = s1_q.row_start ? word_i[7:0]   : blue_hold_q;
    red_d   = word_i[23:16];
    green_d = word_i[15:8];
    blue_d  = word_i[7:0];
    alpha_d = word_i[31:24];
    if (ham6 || ham8) begin
      alpha_d = 8'hff;
      case (sel)
        hpd_pkg::SelBlue: begin
          red_d = base_r; green_d = base_g; blue_d = comp;
        end
        hpd_pkg::SelRed: begin
          red_d = comp; green_d = base_g; blue_d = base_b;
        end
        hpd_pkg::SelGreen: begin
          red_d = base_r; green_d = comp; blue_d = base_b;
        end
        default: begin
          red_d = word_i[23:16]; green_d = word_i[15:8]; blue_d = word_i[7:0];
        end
      endcase
    end
    if (s1_q.mask_en) begin
      alpha_d = s1_q.mask_bit ? 8'hff : 8'h00;
    end
  end

  // Issue stage control, holds and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      red_hold_q   <= 8'd0;
      green_hold_q <= 8'd0;
      blue_hold_q  <= 8'd0;
    end else begin
      if (issue_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q  <= 1'b1;
        red_hold_q   <= red_d;
        green_hold_q <= green_d;
        blue_hold_q  <= blue_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_q <= ctl_i;
    end
    if (adv) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.red   = red_q;
  assign out_if.green = green_q;
  assign out_if.blue  = blue_q;
  assign out_if.alpha = alpha_q;

  // A waiting pixel always moves into an empty output register
  `HPD_ASSERT_NEXT(a_s1_drains, s1_valid_q && !out_valid_q, out_valid_q,
                   "pixel stage stalled with empty output")
  // Held color only changes when a pixel completes
  `HPD_ASSERT_NEXT(a_hold_stable, !adv,
                   $stable(red_hold_q) && $stable(green_hold_q) && $stable(blue_hold_q),
                   "held color changed without a pixel")
  // HAM pixels without masking are opaque
  `HPD_ASSERT_NEXT(a_ham_opaque,
                   adv && !s1_q.mask_en && (ham6 || ham8), alpha_q == 8'hff,
                   "HAM pixel not opaque")
  // New pixel never issued over a stalled one
  `HPD_ASSERT_NOW(a_no_overrun, issue_i && s1_valid_q, adv,
                  "pixel issued over stalled pixel")

endmodule

/* rtl/ham_palette_pixel_decoder_core.sv */
// Path: an accepted pixel word registers its palette read and control in the issue stage,
// then loads the output register once that is free, and the sink takes it from there.
// Throughput: one word per cycle unless the output sink stalls; one palette read port serves each pixel.
// Palette writes are absorbed in the accept cycle and produce no output.
// Reset (async, active low) clears config, held color and palette written flags;
// palette entries read as zero until written, no clearing pass is needed.
module ham_palette_pixel_decoder_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hpd_in_if.sink                     in_if,
  hpd_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpd_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [1:0]        color_mode_q;
  logic              mask_enable_q;
  logic              cfg_we;
  logic              in_acc;
  logic              pix_issue;
  logic              pal_we;
  logic              pix_ready;
  logic [31:0]       pal_word;
  hpd_pkg::pix_ctl_t ctl;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= hpd_pkg::ModeIndexed;
      mask_enable_q <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[2])
        hpd_pkg::RegColorMode:  color_mode_q  <= pwdata[1:0];
        hpd_pkg::RegMaskEnable: mask_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == hpd_pkg::RegMaskEnable) ? {31'd0, mask_enable_q}
                                                       : {30'd0, color_mode_q};

  // Input decode
  assign in_if.ready = pix_ready;
  assign in_acc      = in_if.valid && pix_ready;
  assign pix_issue   = in_acc && (in_if.opcode == hpd_pkg::OpPixel);
  assign pal_we      = in_acc && (in_if.opcode == hpd_pkg::OpPalWrite);

  always_comb begin
    ctl.mode        = color_mode_q;
    ctl.mask_en     = mask_enable_q;
    ctl.row_start   = in_if.row_start;
    ctl.pixel_value = in_if.pixel_value;
    ctl.mask_bit    = in_if.mask_bit;
  end

  hpd_palette u_palette (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (pal_we),
    .widx_i (in_if.entry_index),
    .wword_i(in_if.entry_word),
    .re_i   (pix_issue),
    .ridx_i (hpd_pkg::pal_addr(color_mode_q, in_if.pixel_value)),
    .rword_o(pal_word)
  );

  hpd_pixel u_pixel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(pix_issue),
    .ctl_i  (ctl),
    .ready_o(pix_ready),
    .word_i (pal_word),
    .out_if (out_if)
  );

endmodule
